/* src/aam_pkg.sv */
// Shared types and constants for the approximate 4x4 array multiplier.
// Holds the adder-cell mode codes and the array geometry; no dependencies.
`timescale 1ns / 1ps

package aam_pkg;

    // Array geometry
    localparam int unsigned OPERAND_WIDTH = 4;
    localparam int unsigned PRODUCT_WIDTH = 8;
    localparam int unsigned NUM_CELLS     = 12;
    localparam int unsigned MODE_WIDTH    = 4;
    localparam int unsigned MODES_WIDTH   = NUM_CELLS * MODE_WIDTH;

    typedef logic [MODE_WIDTH-1:0]    cell_mode_t;
    typedef logic [MODES_WIDTH-1:0]   cell_modes_t;
    typedef logic [OPERAND_WIDTH-1:0] operand_t;
    typedef logic [PRODUCT_WIDTH-1:0] product_t;

    // Adder-cell mode codes; any code not listed falls back to majority
    localparam cell_mode_t MODE_SUM_PASS_CARRY = 4'd1;
    localparam cell_mode_t MODE_OR_SUM         = 4'd2;
    localparam cell_mode_t MODE_INV_MAJ_SUM    = 4'd3;
    localparam cell_mode_t MODE_EXACT          = 4'd4;
    localparam cell_mode_t MODE_APPROX_5       = 4'd5;
    localparam cell_mode_t MODE_APPROX_6       = 4'd6;
    localparam cell_mode_t MODE_APPROX_7       = 4'd7;
    localparam cell_mode_t MODE_APPROX_8       = 4'd8;
    localparam cell_mode_t MODE_PASS_D         = 4'd9;
    localparam cell_mode_t MODE_VARIANT_A      = 4'd10;
    localparam cell_mode_t MODE_VARIANT_B      = 4'd11;

    // Every cell exact after reset
    localparam cell_modes_t MODES_RESET = 48'h4444_4444_4444;

endpackage

/* src/aam_cell.sv */
// One configurable partial-product adder cell of the approximate array.
// Depends on aam_pkg for the mode codes.
`timescale 1ns / 1ps

module aam_cell
    import aam_pkg::*;
(
    input  cell_mode_t mode,
    input  logic       x,
    input  logic       y,
    input  logic       d,
    input  logic       c,
    output logic       s,
    output logic       co
);

    logic p;
    logic maj;

    assign p   = x & y;
    assign maj = (c & (p ^ d)) | (p & d);

    // Select sum and carry formula by mode
    always_comb
    begin
        unique case (mode)
            MODE_SUM_PASS_CARRY:
            begin
                s  = p ^ d ^ c;
                co = c;
            end
            MODE_OR_SUM:
            begin
                s  = (p ^ d) | c;
                co = maj;
            end
            MODE_INV_MAJ_SUM:
            begin
                s  = ~maj;
                co = maj;
            end
            MODE_EXACT:
            begin
                s  = p ^ d ^ c;
                co = maj;
            end
            MODE_APPROX_5:
            begin
                s  = c & ~(p ^ d);
                co = (c & (p ^ d)) | (d & (p | (~p & ~c)));
            end
            MODE_APPROX_6:
            begin
                s  = (~c & (p ^ d)) | (~p & ~d);
                co = maj;
            end
            MODE_APPROX_7:
            begin
                s  = ~d & (~p | (p & ~c));
                co = d | (p & ~d & c);
            end
            MODE_APPROX_8:
            begin
                s  = c & (d | (~p & ~d));
                co = p;
            end
            MODE_PASS_D:
            begin
                s  = d;
                co = (d & ~c) | (p & ~(d ^ c));
            end
            MODE_VARIANT_A:
            begin
                s  = c;
                co = ~(((p ^ d) & c) | (~p & ~d));
            end
            MODE_VARIANT_B:
            begin
                s  = ~(p ^ d);
                co = maj;
            end
            default:
            begin
                // Unused codes: majority on both outputs
                s  = maj;
                co = maj;
            end
        endcase
    end

endmodule

/* src/aam_array.sv */
// Combinational 4x4 carry-ripple array of twelve configurable adder cells.
// Depends on aam_pkg and aam_cell.
`timescale 1ns / 1ps

module aam_array
    import aam_pkg::*;
(
    input  operand_t    a,
    input  operand_t    b,
    input  cell_modes_t modes,
    output product_t    product
);

    logic [NUM_CELLS-1:0] cell_x;
    logic [NUM_CELLS-1:0] cell_y;
    logic [NUM_CELLS-1:0] cell_d;
    logic [NUM_CELLS-1:0] cell_c;
    logic [NUM_CELLS-1:0] cell_s;
    logic [NUM_CELLS-1:0] cell_co;

    // Route operand bits, incoming sums and carries to each row of cells
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            cell_x[i]     = a[1];
            cell_x[i + 4] = a[2];
            cell_x[i + 8] = a[3];
            cell_y[i]     = b[i];
            cell_y[i + 4] = b[i];
            cell_y[i + 8] = b[i];
        end

        cell_d[0]  = a[0] & b[1];
        cell_d[1]  = a[0] & b[2];
        cell_d[2]  = a[0] & b[3];
        cell_d[3]  = 1'b0;
        cell_d[4]  = cell_s[1];
        cell_d[5]  = cell_s[2];
        cell_d[6]  = cell_s[3];
        cell_d[7]  = cell_co[3];
        cell_d[8]  = cell_s[5];
        cell_d[9]  = cell_s[6];
        cell_d[10] = cell_s[7];
        cell_d[11] = cell_co[7];

        // Carry ripples along each row, first cell of a row starts at zero
        cell_c[0]  = 1'b0;
        cell_c[1]  = cell_co[0];
        cell_c[2]  = cell_co[1];
        cell_c[3]  = cell_co[2];
        cell_c[4]  = 1'b0;
        cell_c[5]  = cell_co[4];
        cell_c[6]  = cell_co[5];
        cell_c[7]  = cell_co[6];
        cell_c[8]  = 1'b0;
        cell_c[9]  = cell_co[8];
        cell_c[10] = cell_co[9];
        cell_c[11] = cell_co[10];
    end

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        aam_cell u_cell (
            .mode (modes[k*MODE_WIDTH +: MODE_WIDTH]),
            .x    (cell_x[k]),
            .y    (cell_y[k]),
            .d    (cell_d[k]),
            .c    (cell_c[k]),
            .s    (cell_s[k]),
            .co   (cell_co[k])
        );
    end

    // Gather product bits from the array edge
    assign product = {cell_co[11], cell_s[11], cell_s[10], cell_s[9],
                      cell_s[8], cell_s[4], cell_s[0], a[0] & b[0]};

endmodule

/* src/approximate_array_multiplier_4x4.sv */
// Top level of the approximate 4x4 array multiplier: operand register,
// cell-mode register and result register. Depends on aam_pkg and aam_array.
`timescale 1ns / 1ps

// Multiplies two unsigned 4-bit operands through a carry-ripple array of
// twelve adder cells, each running the sum/carry formula picked by its 4-bit
// field in cell_modes (cell i at bits 4i+3:4i; reset gives all cells exact).
// The operands of an accepted transaction are captured in the operand register,
// the array settles from them, and the product is loaded into the result
// register once the output side is free to take it.
// One transaction is accepted every cycle while the output side takes
// results; throughput is set by the single-pass array between those two
// registers. cell_modes is always ready and should be written only while no
// transaction is in flight.
module approximate_array_multiplier_4x4
    import aam_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  operand_t    multiplicand,
    input  operand_t    multiplier_value,
    output logic        out_valid,
    input  logic        out_ready,
    output product_t    product,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cell_modes_t cell_modes
);

    operand_t    a_reg;
    operand_t    b_reg;
    logic        stage_valid_reg;
    logic        stage_valid_next;
    product_t    product_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    cell_modes_t modes_reg;
    product_t    array_product;
    logic        out_advance;
    logic        stage_ready;

    // Handshake: each stage moves when the one after it frees up
    assign out_advance      = ~out_valid_reg | out_ready;
    assign stage_ready      = ~stage_valid_reg | out_advance;
    assign in_ready         = stage_ready;
    assign cfg_ready        = 1'b1;
    assign stage_valid_next = stage_ready ? in_valid : stage_valid_reg;
    assign out_valid_next   = out_advance ? stage_valid_reg : out_valid_reg;

    // Hold the cell modes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modes_reg <= MODES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            modes_reg <= cell_modes;
        end
    end

    // Valid flags of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture operands of an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && stage_ready)
        begin
            a_reg <= multiplicand;
            b_reg <= multiplier_value;
        end
    end

    aam_array u_array (
        .a       (a_reg),
        .b       (b_reg),
        .modes   (modes_reg),
        .product (array_product)
    );

    // Advance the product into the result register
    always_ff @(posedge clk)
    begin
        if (out_advance && stage_valid_reg)
        begin
            product_reg <= array_product;
        end
    end

    assign out_valid = out_valid_reg;
    assign product   = product_reg;

endmodule

/* tb/sv/approximate_array_multiplier_4x4_tb.sv */
// Self-checking testbench for the approximate 4x4 array multiplier.
// Drives operand pairs and cell-mode settings; depends on aam_pkg and the DUT.
`timescale 1ns / 1ps

module approximate_array_multiplier_4x4_tb;
    import aam_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int MAX_GAP        = 13;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 4;
    localparam int ITEMS_PER_SET  = 43;
    localparam int MIXED_SETS     = 8;
    localparam int MODE_CODES     = 1 << MODE_WIDTH;
    localparam int REPORT_LIMIT   = 100;
    localparam int DIRECTED_COUNT = 18;

    // One directed operand pair; a typed-in product is used when known is set
    typedef struct packed {
        operand_t a;
        operand_t b;
        logic     known;
        product_t prod;
    } operand_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    operand_t    multiplicand = '0;
    operand_t    multiplier_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    product_t    product;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cell_modes_t cfg_modes = MODES_RESET;

    // Predictor copy of the register, products awaiting the output side
    cell_modes_t active_modes = MODES_RESET;
    product_t    pending_products[$];
    int          pairs_sent = 0;
    int          products_checked = 0;
    int          mismatches = 0;
    int          settings_run = 0;
    bit          quiet_set = 1'b0;
    bit          hold_request = 1'b0;
    bit          hold_done = 1'b0;

    operand_row_t directed_rows [DIRECTED_COUNT] = '{
        '{4'd0,  4'd0,  1'b1, 8'd0},
        '{4'd15, 4'd15, 1'b1, 8'd225},
        '{4'd15, 4'd0,  1'b1, 8'd0},
        '{4'd0,  4'd15, 1'b1, 8'd0},
        '{4'd1,  4'd15, 1'b1, 8'd15},
        '{4'd15, 4'd1,  1'b1, 8'd15},
        '{4'd1,  4'd1,  1'b1, 8'd1},
        '{4'd8,  4'd8,  1'b1, 8'd64},
        '{4'd5,  4'd10, 1'b1, 8'd50},
        '{4'd10, 4'd5,  1'b1, 8'd50},
        '{4'd7,  4'd9,  1'b1, 8'd63},
        '{4'd3,  4'd3,  1'b1, 8'd9},
        '{4'd12, 4'd13, 1'b1, 8'd156},
        '{4'd6,  4'd6,  1'b1, 8'd36},
        '{4'd9,  4'd14, 1'b1, 8'd126},
        '{4'd11, 4'd7,  1'b1, 8'd77},
        '{4'd2,  4'd4,  1'b0, 8'd0},
        '{4'd13, 4'd11, 1'b0, 8'd0}
    };

    approximate_array_multiplier_4x4 dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .multiplicand     (multiplicand),
        .multiplier_value (multiplier_value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .product          (product),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cell_modes       (cfg_modes)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // One adder cell: carry out in bit 1, sum in bit 0
    function automatic logic [1:0] eval_cell(input cell_mode_t mode, input logic x,
                                             input logic y, input logic d, input logic c);
        logic p;
        logic maj;
        logic s;
        logic co;
        p   = x & y;
        maj = (c & (p ^ d)) | (p & d);
        case (mode)
            MODE_SUM_PASS_CARRY:
            begin
                s  = p ^ d ^ c;
                co = c;
            end
            MODE_OR_SUM:
            begin
                s  = (p ^ d) | c;
                co = maj;
            end
            MODE_INV_MAJ_SUM:
            begin
                s  = ~maj;
                co = maj;
            end
            MODE_EXACT:
            begin
                s  = p ^ d ^ c;
                co = maj;
            end
            MODE_APPROX_5:
            begin
                s  = c & ~(p ^ d);
                co = (c & (p ^ d)) | (d & (p | (~p & ~c)));
            end
            MODE_APPROX_6:
            begin
                s  = (~c & (p ^ d)) | (~p & ~d);
                co = maj;
            end
            MODE_APPROX_7:
            begin
                s  = ~d & (~p | (p & ~c));
                co = d | (p & ~d & c);
            end
            MODE_APPROX_8:
            begin
                s  = c & (d | (~p & ~d));
                co = p;
            end
            MODE_PASS_D:
            begin
                s  = d;
                co = (d & ~c) | (p & ~(d ^ c));
            end
            MODE_VARIANT_A:
            begin
                s  = c;
                co = ~(((p ^ d) & c) | (~p & ~d));
            end
            MODE_VARIANT_B:
            begin
                s  = ~(p ^ d);
                co = maj;
            end
            default:
            begin
                // unused codes give the majority on both outputs
                s  = maj;
                co = maj;
            end
        endcase
        return {co, s};
    endfunction

    // Ripple the operands through the twelve configured cells
    function automatic product_t predict_product(input cell_modes_t modes, input operand_t a,
                                                 input operand_t b);
        logic [NUM_CELLS-1:0] s;
        logic [NUM_CELLS-1:0] co;
        {co[0], s[0]}   = eval_cell(modes[0*MODE_WIDTH +: MODE_WIDTH],
                                    a[1], b[0], a[0] & b[1], 1'b0);
        {co[1], s[1]}   = eval_cell(modes[1*MODE_WIDTH +: MODE_WIDTH],
                                    a[1], b[1], a[0] & b[2], co[0]);
        {co[2], s[2]}   = eval_cell(modes[2*MODE_WIDTH +: MODE_WIDTH],
                                    a[1], b[2], a[0] & b[3], co[1]);
        {co[3], s[3]}   = eval_cell(modes[3*MODE_WIDTH +: MODE_WIDTH],
                                    a[1], b[3], 1'b0, co[2]);
        {co[4], s[4]}   = eval_cell(modes[4*MODE_WIDTH +: MODE_WIDTH],
                                    a[2], b[0], s[1], 1'b0);
        {co[5], s[5]}   = eval_cell(modes[5*MODE_WIDTH +: MODE_WIDTH],
                                    a[2], b[1], s[2], co[4]);
        {co[6], s[6]}   = eval_cell(modes[6*MODE_WIDTH +: MODE_WIDTH],
                                    a[2], b[2], s[3], co[5]);
        {co[7], s[7]}   = eval_cell(modes[7*MODE_WIDTH +: MODE_WIDTH],
                                    a[2], b[3], co[3], co[6]);
        {co[8], s[8]}   = eval_cell(modes[8*MODE_WIDTH +: MODE_WIDTH],
                                    a[3], b[0], s[5], 1'b0);
        {co[9], s[9]}   = eval_cell(modes[9*MODE_WIDTH +: MODE_WIDTH],
                                    a[3], b[1], s[6], co[8]);
        {co[10], s[10]} = eval_cell(modes[10*MODE_WIDTH +: MODE_WIDTH],
                                    a[3], b[2], s[7], co[9]);
        {co[11], s[11]} = eval_cell(modes[11*MODE_WIDTH +: MODE_WIDTH],
                                    a[3], b[3], co[7], co[10]);
        return {co[11], s[11], s[10], s[9], s[8], s[4], s[0], a[0] & b[0]};
    endfunction

    function automatic int draw_gap();
        return quiet_set ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one operand pair and hold it until the DUT accepts it
    task automatic send_operands(input operand_t a, input operand_t b, input logic known,
                                 input product_t typed_prod);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid         <= 1'b1;
        multiplicand     <= a;
        multiplier_value <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_products = {pending_products,
                            (known ? typed_prod : predict_product(active_modes, a, b))};
        pairs_sent++;
    endtask

    // Drop valid and wait until every product has come back
    task automatic drain_array();
        in_valid <= 1'b0;
        while (pending_products.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_modes(input cell_modes_t value);
        cfg_valid <= 1'b1;
        cfg_modes <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid    <= 1'b0;
        active_modes = value;
        settings_run++;
    endtask

    task automatic run_random_set(input cell_modes_t value, input bit with_hold);
        write_modes(value);
        quiet_set = with_hold || ($urandom_range(0, 3) == 0);
        if (with_hold)
            hold_request = 1'b1;
        for (int n = 0; n < ITEMS_PER_SET; n++)
            send_operands(operand_t'($urandom_range(0, 15)), operand_t'($urandom_range(0, 15)),
                          1'b0, '0);
        drain_array();
    endtask

    // Stimulus: reset, directed pairs, then every uniform, several mixed and the reset setting
    initial
    begin
        cell_modes_t mixed;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_operands(directed_rows[i].a, directed_rows[i].b, directed_rows[i].known,
                          directed_rows[i].prod);
        drain_array();

        for (int m = 0; m < MODE_CODES; m++)
            run_random_set({NUM_CELLS{cell_mode_t'(m)}}, 1'b0);

        for (int k = 0; k < MIXED_SETS; k++)
        begin
            if (k % 2 == 0)
            begin
                for (int c = 0; c < NUM_CELLS; c++)
                    mixed[c*MODE_WIDTH +: MODE_WIDTH] = cell_mode_t'($urandom_range(0, 15));
            end
            else
            begin
                mixed = cell_modes_t'({$urandom(), $urandom()});
            end
            run_random_set(mixed, k == 1);
        end

        run_random_set(MODES_RESET, 1'b0);

        $display("Covered %0d operand pairs and %0d products over %0d cell-mode settings,",
                 pairs_sent, products_checked, settings_run);
        $display("each mode code uniform across the array plus mixed and reset settings.");
        if (mismatches == 0 && pending_products.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Output side: random stalls, and one long hold-off to back the array up
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else
            begin
                stall = draw_gap();
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare every completed output transaction with the oldest prediction
    always @(posedge clk)
    begin
        product_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_products.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: product %0d arrived with none expected", $time, product);
            end
            else
            begin
                want = pending_products.pop_front();
                products_checked++;
                if (product !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: product mismatch, expected %0d, actual %0d",
                                 $time, want, product);
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d products outstanding", pending_products.size());
        $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
src/aam_pkg.sv
src/aam_cell.sv
src/aam_array.sv
src/approximate_array_multiplier_4x4.sv
tb/sv/approximate_array_multiplier_4x4_tb.sv
